/* hw/rtl/csev_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csev_pkg - shared definitions for the cubic spline evaluator
// Widths, operation codes, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
package csev_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_POINTS_DEF   = 256;
    localparam int LENGTH_STEPS_DEF = 3;

    // Fixed field widths
    localparam int COORD_BITS = 24;
    localparam int T_W        = 17;
    localparam int LEN_W      = 30;
    localparam int CFG_W      = 9;
    localparam int IDX_W      = 10;    // largest computed point index is 768

    // Datapath widths
    localparam int PT_W   = COORD_BITS + 2;   // virtual point 2*p0-p1 at full width
    localparam int W_W    = 24;               // doubled basis weight, signed Q7.16
    localparam int PROD_W = PT_W + W_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int R_W    = ACC_W - 17;       // evaluated coordinate, unsaturated
    localparam int DIF_W  = PT_W + 1;         // chord coordinate difference magnitude
    localparam int SQ_W   = 2 * DIF_W + 2;    // sum of three squares
    localparam int SQ_ITERS = SQ_W / 2;
    localparam int LACC_W = 34;

    localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);

    // Item operations
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_POS    = 2'd1;
    localparam logic [1:0] OP_DERIV  = 2'd2;
    localparam logic [1:0] OP_LENGTH = 2'd3;

    // Spline modes
    localparam logic [1:0] SPL_LINEAR  = 2'd0;
    localparam logic [1:0] SPL_CATMULL = 2'd1;
    localparam logic [1:0] SPL_BEZIER  = 2'd2;
    localparam logic [1:0] SPL_UNINIT  = 2'd3;

    // Result status
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_UNINIT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SPLINE_MODE = 2'd0;
    localparam logic [1:0] CFG_CLOSED_LOOP = 2'd1;
    localparam logic [1:0] CFG_LOOP_START  = 2'd2;
    localparam logic [1:0] CFG_POINT_COUNT = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;       // capture the input transaction
        logic       wr;         // write point to store
        logic       rd;         // issue store read for point k
        logic       cap;        // capture read data for point k
        logic [1:0] k;
        logic       half;       // second read of the virtual point
        logic       t_item;     // t from the item
        logic       t_zero;     // t = 0, clear length
        logic       t_next;     // next length sample
        logic       t2;
        logic       t3;
        logic       wts;
        logic       mul;
        logic [1:0] mk;
        logic [1:0] mc;
        logic       acc;
        logic       sq_mul;
        logic [1:0] sc;
        logic       sq_acc;
        logic       sqrt_step;
        logic       keep_prev;
        logic       len_add;
        logic       fin;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       err;
        logic       virt;
        logic       lin;
    } t_sts;

endpackage

/* hw/rtl/csev_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csev_ram - generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module csev_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/csev_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csev_dp - spline evaluator datapath
// Config registers, point store, basis weights, multiply-accumulate,
// chord squares, bit-serial square root and result registers.
// ----------------------------------------------------------------------------
module csev_dp #(
    parameter int MAX_POINTS   = csev_pkg::MAX_POINTS_DEF,
    parameter int LENGTH_STEPS = csev_pkg::LENGTH_STEPS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_index,
    input  logic [csev_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  logic [1:0]                             i_mode,
    input  logic [7:0]                             i_point_index,
    input  logic signed [csev_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [csev_pkg::COORD_BITS-1:0] i_point_y,
    input  logic signed [csev_pkg::COORD_BITS-1:0] i_point_z,
    input  logic [7:0]                             i_segment,
    input  logic [csev_pkg::T_W-1:0]               i_t_param,
    input  csev_pkg::t_cmd                         i_cmd,
    output csev_pkg::t_sts                         o_sts,
    output logic signed [csev_pkg::COORD_BITS-1:0] o_out_x,
    output logic signed [csev_pkg::COORD_BITS-1:0] o_out_y,
    output logic signed [csev_pkg::COORD_BITS-1:0] o_out_z,
    output logic [csev_pkg::LEN_W-1:0]             o_seg_length,
    output logic [1:0]                             o_status
);

    localparam int CB     = csev_pkg::COORD_BITS;
    localparam int PT_W   = csev_pkg::PT_W;
    localparam int W_W    = csev_pkg::W_W;
    localparam int PROD_W = csev_pkg::PROD_W;
    localparam int ACC_W  = csev_pkg::ACC_W;
    localparam int R_W    = csev_pkg::R_W;
    localparam int DIF_W  = csev_pkg::DIF_W;
    localparam int SQ_W   = csev_pkg::SQ_W;
    localparam int T_W    = csev_pkg::T_W;
    localparam int IDX_W  = csev_pkg::IDX_W;
    localparam int LACC_W = csev_pkg::LACC_W;
    localparam int LEN_W  = csev_pkg::LEN_W;
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int TQ     = 65536 / LENGTH_STEPS;
    localparam int TR     = 65536 % LENGTH_STEPS;
    localparam int REM_W  = $clog2(LENGTH_STEPS) + 2;

    // Configuration registers
    logic [1:0] r_spline_mode;
    logic       r_closed;
    logic [7:0] r_loop_start;
    logic [8:0] r_point_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spline_mode <= csev_pkg::SPL_UNINIT;
            r_closed      <= 1'b0;
            r_loop_start  <= 8'd0;
            r_point_count <= 9'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                csev_pkg::CFG_SPLINE_MODE: r_spline_mode <= i_cfg_wdata[1:0];
                csev_pkg::CFG_CLOSED_LOOP: r_closed      <= i_cfg_wdata[0];
                csev_pkg::CFG_LOOP_START:  r_loop_start  <= i_cfg_wdata[7:0];
                csev_pkg::CFG_POINT_COUNT: r_point_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Captured transaction
    logic [1:0]           r_op;
    logic [7:0]           r_pidx;
    logic [CB-1:0]        r_px, r_py, r_pz;
    logic [7:0]           r_seg;
    logic [T_W-1:0]       r_tin;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_mode;
            r_pidx <= i_point_index;
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_pz   <= i_point_z;
            r_seg  <= i_segment;
            r_tin  <= i_t_param;
        end
    end

    // Range checks
    logic [8:0] n_pts;
    logic       lin, bez, seg_ok, err;
    logic [1:0] err_code;

    assign n_pts = (32'(r_point_count) > MAX_POINTS) ? 9'(MAX_POINTS) : r_point_count;
    assign lin   = (r_spline_mode == csev_pkg::SPL_LINEAR);
    assign bez   = (r_spline_mode == csev_pkg::SPL_BEZIER);

    always_comb begin
        if (bez) begin
            seg_ok = (11'(r_seg) * 11'd3 + 11'd3) < 11'(n_pts);
        end else begin
            seg_ok = (10'(r_seg) + 10'd1) < (10'(n_pts) + 10'(r_closed));
        end
        if (r_spline_mode == csev_pkg::SPL_UNINIT) begin
            err_code = csev_pkg::ST_UNINIT;
        end else if (!seg_ok) begin
            err_code = csev_pkg::ST_RANGE;
        end else begin
            err_code = csev_pkg::ST_OK;
        end
        err = (r_op != csev_pkg::OP_WRITE) && (err_code != csev_pkg::ST_OK);
    end

    // Point index of control point k (padded layout or Bezier)
    logic [IDX_W-1:0] j, nn, cyc, src_idx, rd_idx;
    logic             virt;

    always_comb begin
        j       = 10'(r_seg) + 10'(i_cmd.k);
        nn      = 10'(n_pts);
        cyc     = 10'(r_loop_start);
        virt    = 1'b0;
        src_idx = '0;
        if (bez) begin
            src_idx = 10'(r_seg) * 10'd3 + 10'(i_cmd.k);
        end else if (j == '0) begin
            if (r_closed && cyc == '0) begin
                src_idx = nn - 10'd1;
            end else begin
                virt = 1'b1;
            end
        end else if (j <= nn) begin
            src_idx = j - 10'd1;
        end else if (j == nn + 10'd1) begin
            src_idx = r_closed ? cyc : nn - 10'd1;
        end else begin
            src_idx = cyc + 10'd1;
        end
        rd_idx = virt ? 10'(i_cmd.half) : src_idx;
    end

    assign o_sts = '{op: r_op, err: err, virt: virt, lin: lin};

    // Point store
    logic [3*CB-1:0] ram_rdata;
    logic            ram_we;
    logic [AW-1:0]   ram_addr;

    assign ram_we   = i_cmd.wr && (32'(r_pidx) < MAX_POINTS);
    assign ram_addr = i_cmd.wr ? AW'(r_pidx) : AW'(rd_idx);

    csev_ram #(
        .WIDTH (3 * CB),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({r_pz, r_py, r_px}),
        .o_rdata (ram_rdata)
    );

    // Point capture; outside the store reads as zero, unused linear taps as zero
    logic                   r_oob;
    logic signed [CB-1:0]   r_pa [3];
    logic signed [PT_W-1:0] r_p [4][3];
    logic                   cap_zero;

    assign cap_zero = r_oob || (lin && (i_cmd.k == 2'd0 || i_cmd.k == 2'd3));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_oob <= (32'(rd_idx) >= MAX_POINTS);
        end
        if (i_cmd.cap) begin
            for (int c = 0; c < 3; c++) begin
                if (!i_cmd.half) begin
                    r_pa[c]          <= cap_zero ? '0 : $signed(ram_rdata[c*CB +: CB]);
                    r_p[i_cmd.k][c]  <= cap_zero ? '0
                                        : PT_W'($signed(ram_rdata[c*CB +: CB]));
                end else begin
                    r_p[i_cmd.k][c]  <= (PT_W'(r_pa[c]) <<< 1)
                                        - PT_W'($signed(ram_rdata[c*CB +: CB]));
                end
            end
        end
    end

    // Parameter t, its powers and the length sample sequence
    logic [T_W-1:0]   r_t, r_t2, r_t3, t_sat;
    logic [REM_W-1:0] r_trem, rem_sum;
    logic [2*T_W-1:0] t2_full, t3_full;

    assign t_sat   = (r_tin > csev_pkg::ONE_Q16) ? csev_pkg::ONE_Q16 : r_tin;
    assign rem_sum = r_trem + REM_W'(TR);
    assign t2_full = (2*T_W)'(r_t) * (2*T_W)'(r_t) + (2*T_W)'(32768);
    assign t3_full = (2*T_W)'(r_t2) * (2*T_W)'(r_t) + (2*T_W)'(32768);

    always_ff @(posedge i_clk) begin
        if (i_cmd.t_item) begin
            r_t <= t_sat;
        end else if (i_cmd.t_zero) begin
            r_t    <= '0;
            r_trem <= '0;
        end else if (i_cmd.t_next) begin
            if (lin) begin
                r_t <= csev_pkg::ONE_Q16;
            end else if (32'(rem_sum) >= LENGTH_STEPS) begin
                r_t    <= r_t + T_W'(TQ + 1);
                r_trem <= rem_sum - REM_W'(LENGTH_STEPS);
            end else begin
                r_t    <= r_t + T_W'(TQ);
                r_trem <= rem_sum;
            end
        end
        if (i_cmd.t2) begin
            r_t2 <= t2_full[16 +: T_W];
        end
        if (i_cmd.t3) begin
            r_t3 <= t3_full[16 +: T_W];
        end
    end

    // Doubled basis weights
    logic signed [W_W-1:0] wt, wt2, wt3, wone;
    logic signed [W_W-1:0] n_w [4];
    logic signed [W_W-1:0] r_w [4];
    logic                  der;

    assign wt   = $signed({{(W_W-T_W){1'b0}}, r_t});
    assign wt2  = $signed({{(W_W-T_W){1'b0}}, r_t2});
    assign wt3  = $signed({{(W_W-T_W){1'b0}}, r_t3});
    assign wone = $signed({{(W_W-T_W){1'b0}}, csev_pkg::ONE_Q16});
    assign der  = (r_op == csev_pkg::OP_DERIV);

    always_comb begin
        n_w[0] = '0;
        n_w[1] = '0;
        n_w[2] = '0;
        n_w[3] = '0;
        case (r_spline_mode)
            csev_pkg::SPL_LINEAR: begin
                n_w[1] = der ? W_W'(-2 * wone) : W_W'(2 * (wone - wt));
                n_w[2] = der ? W_W'(2 * wone) : W_W'(2 * wt);
            end
            csev_pkg::SPL_CATMULL: begin
                if (!der) begin
                    n_w[0] = W_W'(-wt3 + 2 * wt2 - wt);
                    n_w[1] = W_W'(3 * wt3 - 5 * wt2 + 2 * wone);
                    n_w[2] = W_W'(-3 * wt3 + 4 * wt2 + wt);
                    n_w[3] = W_W'(wt3 - wt2);
                end else begin
                    n_w[0] = W_W'(-3 * wt2 + 4 * wt - wone);
                    n_w[1] = W_W'(9 * wt2 - 10 * wt);
                    n_w[2] = W_W'(-9 * wt2 + 8 * wt + wone);
                    n_w[3] = W_W'(3 * wt2 - 2 * wt);
                end
            end
            csev_pkg::SPL_BEZIER: begin
                if (!der) begin
                    n_w[0] = W_W'(2 * (-wt3 + 3 * wt2 - 3 * wt + wone));
                    n_w[1] = W_W'(2 * (3 * wt3 - 6 * wt2 + 3 * wt));
                    n_w[2] = W_W'(2 * (-3 * wt3 + 3 * wt2));
                    n_w[3] = W_W'(2 * wt3);
                end else begin
                    n_w[0] = W_W'(-6 * wt2 + 12 * wt - 6 * wone);
                    n_w[1] = W_W'(18 * wt2 - 24 * wt + 6 * wone);
                    n_w[2] = W_W'(-18 * wt2 + 12 * wt);
                    n_w[3] = W_W'(6 * wt2);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wts) begin
            for (int k = 0; k < 4; k++) begin
                r_w[k] <= n_w[k];
            end
        end
    end

    // Multiply-accumulate, one point coordinate per cycle
    logic signed [PROD_W-1:0] mprod, r_prod;
    logic [1:0]               r_pk, r_pc;
    logic signed [ACC_W-1:0]  r_acc, acc_sum, acc_rnd;
    logic signed [R_W-1:0]    r_r [3];
    logic signed [R_W-1:0]    r_prev [3];

    assign mprod   = PROD_W'(r_p[i_cmd.mk][i_cmd.mc]) * PROD_W'(r_w[i_cmd.mk]);
    assign acc_sum = ((r_pk == 2'd0) ? '0 : r_acc) + ACC_W'(r_prod);
    assign acc_rnd = acc_sum + ACC_W'(65536);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= mprod;
            r_pk   <= i_cmd.mk;
            r_pc   <= i_cmd.mc;
        end
        if (i_cmd.acc) begin
            r_acc <= acc_sum;
            if (r_pk == 2'd3) begin
                r_r[r_pc] <= $signed(acc_rnd[ACC_W-1:17]);
            end
        end
        if (i_cmd.keep_prev || i_cmd.len_add) begin
            for (int c = 0; c < 3; c++) begin
                r_prev[c] <= r_r[c];
            end
        end
    end

    // Chord: squared differences, then digit-by-digit square root
    logic signed [R_W:0]     diff;
    logic [R_W:0]            mag;
    logic [SQ_W-3:0]         sq_prod, r_sqp;
    logic [1:0]              r_sqc;
    logic [SQ_W-1:0]         r_rem, r_res, r_bit, trial;
    logic [LACC_W-1:0]       r_len;

    assign diff    = (R_W+1)'(r_r[i_cmd.sc]) - (R_W+1)'(r_prev[i_cmd.sc]);
    assign mag     = diff[R_W] ? (R_W+1)'(-diff) : (R_W+1)'(diff);
    assign sq_prod = (SQ_W-2)'(mag[DIF_W-1:0]) * (SQ_W-2)'(mag[DIF_W-1:0]);
    assign trial   = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_mul) begin
            r_sqp <= sq_prod;
            r_sqc <= i_cmd.sc;
        end
        if (i_cmd.sq_acc) begin
            if (r_sqc == 2'd0) begin
                r_rem <= SQ_W'(r_sqp);
                r_res <= '0;
                r_bit <= SQ_W'(1) << (SQ_W - 2);
            end else begin
                r_rem <= r_rem + SQ_W'(r_sqp);
            end
        end else if (i_cmd.sqrt_step) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.t_zero) begin
            r_len <= '0;
        end else if (i_cmd.len_add) begin
            r_len <= r_len + LACC_W'(r_res);
        end
    end

    // Result registers
    function automatic logic [CB-1:0] sat_c(input logic signed [R_W-1:0] v);
        logic signed [R_W-1:0] hi;
        logic signed [R_W-1:0] lo;
        hi = $signed({{(R_W-CB+1){1'b0}}, {(CB-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[CB-1:0];
        end else if (v < lo) begin
            return lo[CB-1:0];
        end
        return v[CB-1:0];
    endfunction

    logic [CB-1:0]    r_ox, r_oy, r_oz;
    logic [LEN_W-1:0] r_olen;
    logic [1:0]       r_ost;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_ox   <= '0;
            r_oy   <= '0;
            r_oz   <= '0;
            r_olen <= '0;
            r_ost  <= csev_pkg::ST_OK;
            if (err) begin
                r_ost <= err_code;
            end else if (r_op == csev_pkg::OP_LENGTH) begin
                r_olen <= (r_len > LACC_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                           : r_len[LEN_W-1:0];
            end else if (r_op != csev_pkg::OP_WRITE) begin
                r_ox <= sat_c(r_r[0]);
                r_oy <= sat_c(r_r[1]);
                r_oz <= sat_c(r_r[2]);
            end
        end
    end

    assign o_out_x      = r_ox;
    assign o_out_y      = r_oy;
    assign o_out_z      = r_oz;
    assign o_seg_length = r_olen;
    assign o_status     = r_ost;

endmodule

/* hw/rtl/csev_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csev_ctrl - spline evaluator sequencer
// Steps one transaction through fetch, weights, MAC, chord and result load.
// ----------------------------------------------------------------------------
module csev_ctrl #(
    parameter int LENGTH_STEPS = csev_pkg::LENGTH_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  csev_pkg::t_sts i_sts,
    output csev_pkg::t_cmd o_cmd
);

    localparam int STEP_W = $clog2(LENGTH_STEPS + 1);
    localparam int SI_W   = $clog2(csev_pkg::SQ_ITERS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_WR   = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_CAP  = 4'd4;
    localparam logic [3:0] S_T2   = 4'd5;
    localparam logic [3:0] S_T3   = 4'd6;
    localparam logic [3:0] S_W    = 4'd7;
    localparam logic [3:0] S_MAC  = 4'd8;
    localparam logic [3:0] S_SQ   = 4'd9;
    localparam logic [3:0] S_SQRT = 4'd10;
    localparam logic [3:0] S_ADD  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_k, n_k;
    logic              r_half, n_half;
    logic [3:0]        r_mi, n_mi;
    logic [1:0]        r_sc, n_sc;
    logic [SI_W-1:0]   r_si, n_si;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_first, n_first;
    logic              r_ovalid, n_ovalid;
    logic              step_last;
    csev_pkg::t_cmd    cmd;

    assign step_last = i_sts.lin ? (r_step == STEP_W'(1))
                                 : (r_step == STEP_W'(LENGTH_STEPS));

    // Next state and commands
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_k     = r_k;
        n_half  = r_half;
        n_mi    = r_mi;
        n_sc    = r_sc;
        n_si    = r_si;
        n_step  = r_step;
        n_first = r_first;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.op == csev_pkg::OP_WRITE) begin
                    n_state = S_WR;
                end else if (i_sts.err) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = 2'd0;
                    n_half  = 1'b0;
                    n_state = S_RD;
                end
            end
            S_WR: begin
                cmd.wr  = 1'b1;
                n_state = S_FIN;
            end
            S_RD: begin
                cmd.rd   = 1'b1;
                cmd.k    = r_k;
                cmd.half = r_half;
                n_state  = S_CAP;
            end
            S_CAP: begin
                cmd.cap  = 1'b1;
                cmd.k    = r_k;
                cmd.half = r_half;
                if (!r_half && i_sts.virt) begin
                    n_half  = 1'b1;
                    n_state = S_RD;
                end else begin
                    n_half = 1'b0;
                    if (r_k == 2'd3) begin
                        if (i_sts.op == csev_pkg::OP_LENGTH) begin
                            cmd.t_zero = 1'b1;
                            n_first    = 1'b1;
                        end else begin
                            cmd.t_item = 1'b1;
                            n_first    = 1'b0;
                        end
                        n_state = S_T2;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_RD;
                    end
                end
            end
            S_T2: begin
                cmd.t2  = 1'b1;
                n_state = S_T3;
            end
            S_T3: begin
                cmd.t3  = 1'b1;
                n_state = S_W;
            end
            S_W: begin
                cmd.wts = 1'b1;
                n_mi    = 4'd0;
                n_state = S_MAC;
            end
            // products for index c*4+k, each accumulated in the cycle after it
            S_MAC: begin
                cmd.mk = r_mi[1:0];
                cmd.mc = r_mi[3:2];
                cmd.mul = (r_mi < 4'd12);
                cmd.acc = (r_mi != 4'd0) && (r_mi <= 4'd12);
                if (r_mi == 4'd13) begin
                    if (i_sts.op != csev_pkg::OP_LENGTH) begin
                        n_state = S_FIN;
                    end else if (r_first) begin
                        cmd.keep_prev = 1'b1;
                        cmd.t_next    = 1'b1;
                        n_first       = 1'b0;
                        n_step        = STEP_W'(1);
                        n_state       = S_T2;
                    end else begin
                        n_sc    = 2'd0;
                        n_state = S_SQ;
                    end
                end else begin
                    n_mi = r_mi + 4'd1;
                end
            end
            S_SQ: begin
                cmd.sc     = r_sc;
                cmd.sq_mul = (r_sc != 2'd3);
                cmd.sq_acc = (r_sc != 2'd0);
                if (r_sc == 2'd3) begin
                    n_si    = '0;
                    n_state = S_SQRT;
                end else begin
                    n_sc = r_sc + 2'd1;
                end
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (r_si == SI_W'(csev_pkg::SQ_ITERS - 1)) begin
                    n_state = S_ADD;
                end else begin
                    n_si = r_si + SI_W'(1);
                end
            end
            S_ADD: begin
                cmd.len_add = 1'b1;
                if (step_last) begin
                    n_state = S_FIN;
                end else begin
                    cmd.t_next = 1'b1;
                    n_step     = r_step + STEP_W'(1);
                    n_state    = S_T2;
                end
            end
            S_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ovalid = cmd.fin | (r_ovalid & i_stall);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= 2'd0;
            r_half   <= 1'b0;
            r_mi     <= 4'd0;
            r_sc     <= 2'd0;
            r_si     <= '0;
            r_step   <= '0;
            r_first  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_half   <= n_half;
            r_mi     <= n_mi;
            r_sc     <= n_sc;
            r_si     <= n_si;
            r_step   <= n_step;
            r_first  <= n_first;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_cmd   = cmd;

endmodule

/* hw/rtl/cubic_spline_evaluator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_spline_evaluator_unit - linear / Catmull-Rom / cubic Bezier evaluator
// Keeps a store of 3-D control points (signed Q16.8), written by write
// transactions, and returns the position, derivative or approximate length of
// one segment at t (Q1.16). One transaction is in work at a time; the next is
// taken while the previous result still waits in the output register. A point
// write passes check, store write and result load; an error, check and result
// load. Position and derivative take four point reads from the single-port
// store (one extra for the virtual leading point), t^2 and t^3 in turn, the
// weights and twelve serial multiply-accumulates. A length evaluates
// LENGTH_STEPS+1 samples of t on the shared MAC and sums the chords between
// them (linear mode uses one chord) with the 28-step bit-serial square root.
// ----------------------------------------------------------------------------
module cubic_spline_evaluator_unit #(
    parameter int MAX_POINTS   = csev_pkg::MAX_POINTS_DEF,
    parameter int LENGTH_STEPS = csev_pkg::LENGTH_STEPS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_index,
    input  logic [csev_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [1:0]                             i_mode,
    input  logic [7:0]                             i_point_index,
    input  logic signed [csev_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [csev_pkg::COORD_BITS-1:0] i_point_y,
    input  logic signed [csev_pkg::COORD_BITS-1:0] i_point_z,
    input  logic [7:0]                             i_segment,
    input  logic [csev_pkg::T_W-1:0]               i_t_param,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [csev_pkg::COORD_BITS-1:0] o_out_x,
    output logic signed [csev_pkg::COORD_BITS-1:0] o_out_y,
    output logic signed [csev_pkg::COORD_BITS-1:0] o_out_z,
    output logic [csev_pkg::LEN_W-1:0]             o_seg_length,
    output logic [1:0]                             o_status
);

    csev_pkg::t_cmd cmd;
    csev_pkg::t_sts sts;

    // Sequencer
    csev_ctrl #(
        .LENGTH_STEPS (LENGTH_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath
    csev_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .LENGTH_STEPS (LENGTH_STEPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_mode        (i_mode),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_segment     (i_segment),
        .i_t_param     (i_t_param),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_seg_length  (o_seg_length),
        .o_status      (o_status)
    );

endmodule
